@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, masked while reset is high
`define DFW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

// next-cycle implication that also holds across reset
`define DFW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

@@ rtl/dfw_pkg.sv @@
// types, constants and register codes for the disparity forward warp block
// no dependencies
`timescale 1ns / 1ps

package dfw_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int NUM_BANKS = 2;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int EW_W      = COL_W + 1;
   localparam int DISP_W    = 8;
   localparam int CHAN_W    = 8;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 1;
   localparam int CMP_W     = (EW_W > CSR_W) ? EW_W : CSR_W;
   localparam int SUM_W     = ((COL_W > DISP_W) ? COL_W : DISP_W) + 1;

   localparam int OQ_DEPTH  = 4;
   localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W  = OQ_PTR_W + 1;

   localparam logic [CSR_W-1:0]     ROW_WIDTH_RESET = CSR_W'(1024);
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_VIEW   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH   = CSR_IDX_W'(1);
   localparam logic                 OP_FLUSH        = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic              opcode;
      logic [DISP_W-1:0] disparity;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              hole;
      logic              row_end;
   } rsp_payload_type;

   // one z-buffer entry: disparity 0 means nothing landed here
   typedef struct packed {
      logic [DISP_W-1:0] disp;
      color_type         color;
   } mem_word_type;

   localparam int MEM_W = $bits(mem_word_type);

   // accepted item as seen by the z-buffer
   typedef struct packed {
      logic              go;
      logic              emit;
      logic              load;
      logic              bank;
      logic              row_end;
      logic [COL_W-1:0]  col;
      logic [COL_W-1:0]  target;
      logic [DISP_W-1:0] disp;
      color_type         color;
   } zb_req_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } zb_clr_type;

   typedef struct packed {
      logic            busy;
      logic            valid;
      rsp_payload_type data;
   } zb_out_type;

endpackage

@@ rtl/dfw_ram.sv @@
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module dfw_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read returns the old word when the same entry is written in that cycle
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/dfw_zbuf.sv @@
// double-banked z-buffer: two row rams, read-modify-write with forwarding
// depends on dfw_pkg and dfw_ram
`timescale 1ns / 1ps

module dfw_zbuf (
   input  logic                clock,
   input  logic                reset,
   input  dfw_pkg::zb_req_type req,
   input  dfw_pkg::zb_clr_type clr,
   output dfw_pkg::zb_out_type res
);

   import dfw_pkg::*;

   logic         s1_valid_ff;
   zb_req_type   s1_ff;
   mem_word_type q [NUM_BANKS];
   mem_word_type em_q;
   logic         written;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req.go;
      end
   end

   always_ff @(posedge clock) begin
      if (req.go) begin
         s1_ff <= req;
      end
   end

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      localparam logic BANK_ID = 1'(b);

      logic [COL_W-1:0] raddr;
      logic [COL_W-1:0] s1_addr_ff;
      logic [MEM_W-1:0] rdata;
      logic             ld_we;
      logic             em_we;
      logic             we;
      logic [COL_W-1:0] waddr;
      mem_word_type     wdata;
      mem_word_type     new_word;
      logic             fwd_we_ff;
      logic [COL_W-1:0] fwd_addr_ff;
      mem_word_type     fwd_data_ff;

      // the loading bank is read at the target, the other bank at the column
      assign raddr = (req.bank == BANK_ID) ? req.target : req.col;

      always_ff @(posedge clock) begin
         if (req.go) begin
            s1_addr_ff <= raddr;
         end
      end

      dfw_ram #(
         .DEPTH(MAX_WIDTH),
         .WIDTH(MEM_W)
      ) u_ram (
         .clock(clock),
         .we   (we),
         .waddr(waddr),
         .wdata(wdata),
         .re   (req.go),
         .raddr(raddr),
         .rdata(rdata)
      );

      // a write landing on the edge of the read is not in the ram data yet
      assign q[b] = (fwd_we_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff
                                                             : mem_word_type'(rdata);

      assign ld_we = s1_valid_ff && (s1_ff.bank == BANK_ID) && s1_ff.load &&
                     (s1_ff.disp > q[b].disp);
      assign em_we = s1_valid_ff && (s1_ff.bank != BANK_ID) && s1_ff.emit;

      assign new_word.disp  = s1_ff.disp;
      assign new_word.color = s1_ff.color;

      // emitted entries go back to zero so the bank is empty when it reloads
      assign we    = clr.en || ld_we || em_we;
      assign waddr = clr.en ? clr.addr : s1_addr_ff;
      assign wdata = (clr.en || !ld_we) ? '0 : new_word;

      always_ff @(posedge clock) begin
         if (reset) begin
            fwd_we_ff <= 1'b0;
         end else begin
            fwd_we_ff <= we;
         end
      end

      always_ff @(posedge clock) begin
         fwd_addr_ff <= waddr;
         fwd_data_ff <= wdata;
      end
   end

   assign em_q    = q[~s1_ff.bank];
   assign written = (em_q.disp != '0);

   assign res.busy           = s1_valid_ff;
   assign res.valid          = s1_valid_ff && s1_ff.emit;
   assign res.data.red_out   = written ? em_q.color.red   : '0;
   assign res.data.green_out = written ? em_q.color.green : '0;
   assign res.data.blue_out  = written ? em_q.color.blue  : '0;
   assign res.data.hole      = !written;
   assign res.data.row_end   = s1_ff.row_end;

endmodule

@@ rtl/dfw_outq.sv @@
// result queue between the z-buffer stage and the rsp channel
// depends on dfw_pkg
`timescale 1ns / 1ps

module dfw_outq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  dfw_pkg::rsp_payload_type        push_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dfw_pkg::rsp_payload_type        rsp_data,
   output logic [dfw_pkg::OQ_CNT_W-1:0]    count
);

   import dfw_pkg::*;

   rsp_payload_type     slot_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] wr_ptr_ff;
   logic [OQ_PTR_W-1:0] wr_ptr_in;
   logic [OQ_PTR_W-1:0] rd_ptr_ff;
   logic [OQ_PTR_W-1:0] rd_ptr_in;
   logic [OQ_CNT_W-1:0] count_ff;
   logic [OQ_CNT_W-1:0] count_in;
   logic                pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + OQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + OQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/disparity_forward_warp_zbuffer.sv @@
// Forward warp of a pixel stream by disparity with a double-banked z-buffer.
// A result passes the z-buffer stage register and then the result queue.
// Throughput: one item per cycle while req_stall is low; the z-buffer rams
// do one read and one write per bank each cycle, forwarding the last write.
// Reset (synchronous) and every row_width write start a clearing pass of
// MAX_WIDTH (2048) entries in both banks; req_stall stays high during it.
`timescale 1ns / 1ps

module disparity_forward_warp_zbuffer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dfw_pkg::req_payload_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dfw_pkg::rsp_payload_type         rsp_data,
   input  logic                             csr_we,
   input  logic [dfw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dfw_pkg::CSR_W-1:0]        csr_wdata
);

   import dfw_pkg::*;

   function automatic logic [EW_W-1:0] sat_width(input logic [CSR_W-1:0] v);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (ext == '0) begin
         return EW_W'(1);
      end else if (ext > CMP_W'(MAX_WIDTH)) begin
         return EW_W'(MAX_WIDTH);
      end
      return EW_W'(ext);
   endfunction

   logic             left_view_ff, left_view_in;
   logic [EW_W-1:0]  width_ff, width_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             bank_ff, bank_in;
   logic             prev_ready_ff, prev_ready_in;
   logic             clearing_ff, clearing_in;
   logic [COL_W-1:0] sweep_ff, sweep_in;

   logic             accept;
   logic [SUM_W-1:0] col_ext;
   logic [SUM_W-1:0] disp_ext;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] diff;
   logic             disp_live;
   logic             in_range;
   logic [EW_W-1:0]  col_inc;
   logic             wrap;
   logic [OQ_CNT_W-1:0] oq_count;
   logic [OQ_CNT_W-1:0] occupancy;

   zb_req_type zb_req;
   zb_clr_type zb_clr;
   zb_out_type zb_res;

   // room for this item and the one in the z-buffer stage
   assign occupancy = oq_count + OQ_CNT_W'(zb_res.busy);
   assign req_stall = clearing_ff || (occupancy > OQ_CNT_W'(OQ_DEPTH - 2));
   assign accept    = req_valid && !req_stall;

   // target column
   assign col_ext   = SUM_W'(col_ff);
   assign disp_ext  = SUM_W'(req_data.disparity);
   assign sum       = col_ext + disp_ext;
   assign diff      = col_ext - disp_ext;
   assign disp_live = (req_data.opcode != OP_FLUSH) && (req_data.disparity != '0);
   assign in_range  = left_view_ff ? (disp_ext <= col_ext) : (sum < SUM_W'(width_ff));
   assign col_inc   = EW_W'(col_ff) + EW_W'(1);
   assign wrap      = (col_inc == width_ff);

   always_comb begin
      zb_req.go          = accept;
      zb_req.emit        = prev_ready_ff;
      zb_req.load        = disp_live && in_range;
      zb_req.bank        = bank_ff;
      zb_req.row_end     = wrap;
      zb_req.col         = col_ff;
      zb_req.target      = left_view_ff ? COL_W'(diff) : COL_W'(sum);
      zb_req.disp        = req_data.disparity;
      zb_req.color.red   = req_data.red_in;
      zb_req.color.green = req_data.green_in;
      zb_req.color.blue  = req_data.blue_in;
   end

   assign zb_clr.en   = clearing_ff;
   assign zb_clr.addr = sweep_ff;

   always_comb begin
      left_view_in  = left_view_ff;
      width_in      = width_ff;
      col_in        = col_ff;
      bank_in       = bank_ff;
      prev_ready_in = prev_ready_ff;
      clearing_in   = clearing_ff;
      sweep_in      = sweep_ff;

      if (clearing_ff) begin
         sweep_in = sweep_ff + COL_W'(1);
         if (sweep_ff == COL_W'(MAX_WIDTH - 1)) begin
            clearing_in = 1'b0;
         end
      end

      if (accept) begin
         if (wrap) begin
            col_in        = '0;
            bank_in       = ~bank_ff;
            prev_ready_in = 1'b1;
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end

      if (csr_we) begin
         case (csr_index)
            CSR_LEFT_VIEW: begin
               left_view_in = csr_wdata[0];
            end
            CSR_ROW_WIDTH: begin
               // restart the stream and wipe both banks
               width_in      = sat_width(csr_wdata);
               col_in        = '0;
               bank_in       = 1'b0;
               prev_ready_in = 1'b0;
               clearing_in   = 1'b1;
               sweep_in      = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_view_ff  <= 1'b0;
         width_ff      <= sat_width(ROW_WIDTH_RESET);
         col_ff        <= '0;
         bank_ff       <= 1'b0;
         prev_ready_ff <= 1'b0;
         clearing_ff   <= 1'b1;
         sweep_ff      <= '0;
      end else begin
         left_view_ff  <= left_view_in;
         width_ff      <= width_in;
         col_ff        <= col_in;
         bank_ff       <= bank_in;
         prev_ready_ff <= prev_ready_in;
         clearing_ff   <= clearing_in;
         sweep_ff      <= sweep_in;
      end
   end

   dfw_zbuf u_zbuf (
      .clock(clock),
      .reset(reset),
      .req  (zb_req),
      .clr  (zb_clr),
      .res  (zb_res)
   );

   dfw_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (zb_res.valid),
      .push_data(zb_res.data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .count    (oq_count)
   );

endmodule

@@ rtl/dfw_checker.sv @@
// port-level checks for the disparity forward warp block, bound to the top
// depends on dfw_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfw_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input dfw_pkg::rsp_payload_type      rsp_data,
   input logic                          csr_we,
   input logic [dfw_pkg::CSR_IDX_W-1:0] csr_index
);

   import dfw_pkg::*;

   // reset starts the clearing pass, so no item can get in right after it
   `DFW_ASSERT_NEXT_ALWAYS(a_reset_stalls, clock, reset, req_stall)

   // reset leaves no result pending
   `DFW_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // a row width write restarts the stream and wipes the banks
   `DFW_ASSERT_NEXT(a_width_restart, clock, reset, csr_we && (csr_index == CSR_ROW_WIDTH), req_stall)

   // a stalled result stays valid and unchanged while stalled
   `DFW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // fires only if req_stall was high at the accept, so it never fires
   `DFW_ASSERT_NEXT(a_req_seen, clock, reset, req_valid && !req_stall && !csr_we, !(req_stall && !rsp_stall && !rsp_valid && $past(req_stall)))

endmodule

bind disparity_forward_warp_zbuffer dfw_checker u_dfw_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data),
   .csr_we   (csr_we),
   .csr_index(csr_index)
);
